// ===== hdl/dndc_pkg.sv =====
// ============================================================================
// dndc_pkg
// Shared types, codes and constants of the descriptor NIC DMA controller.
// ============================================================================
package dndc_pkg;

    localparam int DESC_BYTES_DEF   = 16;
    localparam int MAX_TX_FRAME_DEF = 4096;
    localparam int MAX_RX_FRAME_DEF = 2048;

    // command queue between front and back (power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 64;

    // register window offsets
    localparam logic [63:0] OFF_TX_BASE = 64'd0;
    localparam logic [63:0] OFF_RX_BASE = 64'd8;
    localparam logic [63:0] OFF_TX_DOOR = 64'd16;
    localparam logic [63:0] OFF_RX_DOOR = 64'd20;

    localparam logic [15:0] IRQ_LEN = 16'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_IRQ_ADDR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_IRQ_DATA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_IRQ_ADDR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_IRQ_DATA = 3'd4;

    // request functions
    localparam logic [2:0] FUNC_HOST_WR  = 3'd0;
    localparam logic [2:0] FUNC_TX_DESC  = 3'd1;
    localparam logic [2:0] FUNC_TX_FRAME = 3'd2;
    localparam logic [2:0] FUNC_RX_DESC  = 3'd3;
    localparam logic [2:0] FUNC_RX_FRAME = 3'd4;

    // result kinds
    localparam logic [2:0] KIND_STATUS = 3'd0;
    localparam logic [2:0] KIND_READ   = 3'd1;
    localparam logic [2:0] KIND_PKTWR  = 3'd2;
    localparam logic [2:0] KIND_DESCWR = 3'd3;
    localparam logic [2:0] KIND_IRQ    = 3'd4;
    localparam logic [2:0] KIND_XMIT   = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOBASE    = 3'd1;
    localparam logic [2:0] ST_DESCFAIL  = 3'd2;
    localparam logic [2:0] ST_FRAMEFAIL = 3'd3;
    localparam logic [2:0] ST_BUSY      = 3'd4;
    localparam logic [2:0] ST_NOTREADY  = 3'd5;
    localparam logic [2:0] ST_UNEXP     = 3'd6;
    localparam logic [2:0] ST_TOOLONG   = 3'd7;

    typedef enum logic [2:0] {
        CMD_STATUS = 3'd0,
        CMD_READ   = 3'd1,
        CMD_TXIRQ  = 3'd2,
        CMD_XMIT   = 3'd3,
        CMD_RXPKT  = 3'd4
    } cmd_op_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [63:0] reg_addr;
        logic [63:0] reg_data;
        logic        ok;
        logic [63:0] buffer_addr;
        logic [15:0] frame_len;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] target_addr;
        logic [63:0] payload;
        logic [15:0] length;
        logic [2:0]  status;
        logic        last;
    } out_item_t;

    // classified request handed from front to back
    typedef struct packed {
        cmd_op_t     op;
        logic [2:0]  status;
        logic [63:0] addr;
        logic [63:0] aux;
        logic [15:0] len;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [63:0] tx_irq_addr;
        logic [31:0] tx_irq_data;
        logic [63:0] rx_irq_addr;
        logic [31:0] rx_irq_data;
    } irq_cfg_t;

endpackage

// ===== hdl/descriptor_nic_dma_controller_unit.sv =====
// ============================================================================
// descriptor_nic_dma_controller_unit
// NIC register window and DMA sequencer: doorbells, descriptor and frame
// reads, transmit hand-off, receive writeback and interrupt writes.
// ============================================================================
// A request is accepted in the cycle it is offered as long as the four-entry
// command queue between the decode front and the issue back has room; the
// front updates ring bases and TX/RX phases at once, so dependent requests
// may follow back to back. Each request yields zero to three results, issued
// one per cycle while the sink is ready, from a registered output: a received
// frame gives three results, a transmit completion two, any other queued
// request one. Sustained throughput is therefore set by the result port.
// Configuration writes take effect on the next cycle.
module descriptor_nic_dma_controller_unit #(
    parameter int DESC_BYTES   = dndc_pkg::DESC_BYTES_DEF,
    parameter int MAX_TX_FRAME = dndc_pkg::MAX_TX_FRAME_DEF,
    parameter int MAX_RX_FRAME = dndc_pkg::MAX_RX_FRAME_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dndc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dndc_pkg::CFG_DAT_W-1:0]   cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  dndc_pkg::in_item_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output dndc_pkg::out_item_t              m_data
);

    logic [63:0]         bar_base_reg;
    dndc_pkg::irq_cfg_t  irq_cfg_reg;
    logic                q_push;
    logic                q_pop;
    dndc_pkg::cmd_t      q_in;
    dndc_pkg::cmd_t      q_head;
    dndc_pkg::q_status_t q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar_base_reg <= '0;
            irq_cfg_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dndc_pkg::CFG_BAR_BASE:    bar_base_reg             <= cfg_wr_data;
                dndc_pkg::CFG_TX_IRQ_ADDR: irq_cfg_reg.tx_irq_addr <= cfg_wr_data;
                dndc_pkg::CFG_TX_IRQ_DATA: irq_cfg_reg.tx_irq_data <= cfg_wr_data[31:0];
                dndc_pkg::CFG_RX_IRQ_ADDR: irq_cfg_reg.rx_irq_addr <= cfg_wr_data;
                dndc_pkg::CFG_RX_IRQ_DATA: irq_cfg_reg.rx_irq_data <= cfg_wr_data[31:0];
                default: begin
                end
            endcase
        end
    end

    dndc_front #(
        .DESC_BYTES   (DESC_BYTES),
        .MAX_TX_FRAME (MAX_TX_FRAME),
        .MAX_RX_FRAME (MAX_RX_FRAME)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .bar_base (bar_base_reg),
        .q_stat   (q_stat),
        .cmd_push (q_push),
        .cmd      (q_in)
    );

    dndc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .stat     (q_stat)
    );

    dndc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_stat  (q_stat),
        .pop     (q_pop),
        .irq_cfg (irq_cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("command queue underflow");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid)
        else $error("result burst broken before last");

    a_empty_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty");

endmodule

// ===== hdl/dndc_queue.sv =====
// ============================================================================
// dndc_queue
// Short command FIFO between the classifying front and the issuing back.
// ============================================================================
module dndc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dndc_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output dndc_pkg::cmd_t      head,
    output dndc_pkg::q_status_t stat
);

    dndc_pkg::cmd_t                  mem_reg [dndc_pkg::QDEPTH];
    logic [dndc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dndc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dndc_pkg::QCNT_W-1:0]     count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == dndc_pkg::QCNT_W'(dndc_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ===== hdl/dndc_front.sv =====
// ============================================================================
// dndc_front
// Accepts requests, decodes the register window, tracks the TX and RX phases
// and queues one command per request that yields results.
// ============================================================================
module dndc_front #(
    parameter int DESC_BYTES   = dndc_pkg::DESC_BYTES_DEF,
    parameter int MAX_TX_FRAME = dndc_pkg::MAX_TX_FRAME_DEF,
    parameter int MAX_RX_FRAME = dndc_pkg::MAX_RX_FRAME_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dndc_pkg::in_item_t  s_data,
    input  logic [63:0]         bar_base,
    input  dndc_pkg::q_status_t q_stat,
    output logic                cmd_push,
    output dndc_pkg::cmd_t      cmd
);

    localparam int DW    = $clog2(DESC_BYTES + 1);
    localparam int PROD_W = 32 + DW;

    typedef enum logic [2:0] {
        TX_IDLE  = 3'b001,
        TX_DESC  = 3'b010,
        TX_FRAME = 3'b100
    } tx_state_t;

    typedef enum logic [3:0] {
        RX_INIT  = 4'b0001,
        RX_DESC  = 4'b0010,
        RX_READY = 4'b0100,
        RX_DONE  = 4'b1000
    } rx_state_t;

    tx_state_t   tx_state_reg, tx_state_next;
    rx_state_t   rx_state_reg, rx_state_next;
    logic [63:0] tx_base_reg, tx_base_next;
    logic [63:0] rx_base_reg, rx_base_next;
    logic [63:0] rx_desc_reg, rx_desc_next;
    logic [63:0] rx_buf_reg, rx_buf_next;
    logic [63:0] tx_faddr_reg, tx_faddr_next;
    logic [15:0] tx_flen_reg, tx_flen_next;

    logic              accept;
    logic              cmd_valid;
    logic [63:0]       off;
    logic [63:0]       ring_base;
    logic [PROD_W-1:0] idx_scaled;
    logic [63:0]       desc_addr;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    assign off        = s_data.reg_addr - bar_base;
    assign ring_base  = (off == dndc_pkg::OFF_RX_DOOR) ? rx_base_reg : tx_base_reg;
    assign idx_scaled = PROD_W'(s_data.reg_data[31:0]) * PROD_W'(DESC_BYTES);
    assign desc_addr  = ring_base + 64'(idx_scaled);

    always_comb begin
        cmd.op        = dndc_pkg::CMD_STATUS;
        cmd.status    = dndc_pkg::ST_UNEXP;
        cmd.addr      = '0;
        cmd.aux       = '0;
        cmd.len       = '0;
        cmd_valid     = 1'b1;
        tx_state_next = tx_state_reg;
        rx_state_next = rx_state_reg;
        tx_base_next  = tx_base_reg;
        rx_base_next  = rx_base_reg;
        rx_desc_next  = rx_desc_reg;
        rx_buf_next   = rx_buf_reg;
        tx_faddr_next = tx_faddr_reg;
        tx_flen_next  = tx_flen_reg;
        case (s_data.func)
            dndc_pkg::FUNC_HOST_WR: begin
                cmd.status = dndc_pkg::ST_OK;
                if (off == dndc_pkg::OFF_TX_BASE) begin
                    tx_base_next = s_data.reg_data;
                end else if (off == dndc_pkg::OFF_RX_BASE) begin
                    rx_base_next = s_data.reg_data;
                end else if (off == dndc_pkg::OFF_TX_DOOR) begin
                    if (tx_state_reg != TX_IDLE) begin
                        cmd.status = dndc_pkg::ST_BUSY;
                    end else if (tx_base_reg == '0) begin
                        cmd.op     = dndc_pkg::CMD_TXIRQ;
                        cmd.status = dndc_pkg::ST_NOBASE;
                    end else begin
                        cmd.op        = dndc_pkg::CMD_READ;
                        cmd.addr      = desc_addr;
                        cmd.len       = 16'(DESC_BYTES);
                        tx_state_next = TX_DESC;
                    end
                end else if (off == dndc_pkg::OFF_RX_DOOR) begin
                    if (rx_base_reg == '0) begin
                        cmd.status = dndc_pkg::ST_NOBASE;
                    end else if (rx_state_reg == RX_DESC || rx_state_reg == RX_READY) begin
                        cmd.status = dndc_pkg::ST_BUSY;
                    end else begin
                        cmd.op        = dndc_pkg::CMD_READ;
                        cmd.addr      = desc_addr;
                        cmd.len       = 16'(DESC_BYTES);
                        rx_desc_next  = desc_addr;
                        rx_state_next = RX_DESC;
                    end
                end else begin
                    cmd_valid = 1'b0;
                end
            end
            dndc_pkg::FUNC_TX_DESC: begin
                if (tx_state_reg != TX_DESC) begin
                    cmd.status = dndc_pkg::ST_UNEXP;
                end else if (!s_data.ok) begin
                    cmd.op        = dndc_pkg::CMD_TXIRQ;
                    cmd.status    = dndc_pkg::ST_DESCFAIL;
                    tx_state_next = TX_IDLE;
                end else if (s_data.frame_len > 16'(MAX_TX_FRAME)) begin
                    cmd.op        = dndc_pkg::CMD_TXIRQ;
                    cmd.status    = dndc_pkg::ST_TOOLONG;
                    tx_state_next = TX_IDLE;
                end else begin
                    cmd.op        = dndc_pkg::CMD_READ;
                    cmd.status    = dndc_pkg::ST_OK;
                    cmd.addr      = s_data.buffer_addr;
                    cmd.len       = s_data.frame_len;
                    tx_faddr_next = s_data.buffer_addr;
                    tx_flen_next  = s_data.frame_len;
                    tx_state_next = TX_FRAME;
                end
            end
            dndc_pkg::FUNC_TX_FRAME: begin
                if (tx_state_reg != TX_FRAME) begin
                    cmd.status = dndc_pkg::ST_UNEXP;
                end else if (!s_data.ok) begin
                    cmd.op        = dndc_pkg::CMD_TXIRQ;
                    cmd.status    = dndc_pkg::ST_FRAMEFAIL;
                    tx_state_next = TX_IDLE;
                end else begin
                    cmd.op        = dndc_pkg::CMD_XMIT;
                    cmd.status    = dndc_pkg::ST_OK;
                    cmd.addr      = tx_faddr_reg;
                    cmd.len       = tx_flen_reg;
                    tx_state_next = TX_IDLE;
                end
            end
            dndc_pkg::FUNC_RX_DESC: begin
                if (rx_state_reg != RX_DESC) begin
                    cmd.status = dndc_pkg::ST_UNEXP;
                end else if (!s_data.ok) begin
                    cmd.status    = dndc_pkg::ST_DESCFAIL;
                    rx_state_next = RX_INIT;
                end else begin
                    cmd.status    = dndc_pkg::ST_OK;
                    rx_buf_next   = s_data.buffer_addr;
                    rx_state_next = RX_READY;
                end
            end
            dndc_pkg::FUNC_RX_FRAME: begin
                if (rx_state_reg != RX_READY) begin
                    cmd.status = dndc_pkg::ST_NOTREADY;
                end else if (s_data.frame_len > 16'(MAX_RX_FRAME)) begin
                    cmd.status = dndc_pkg::ST_TOOLONG;
                end else begin
                    cmd.op        = dndc_pkg::CMD_RXPKT;
                    cmd.status    = dndc_pkg::ST_OK;
                    cmd.addr      = rx_buf_reg;
                    cmd.aux       = rx_desc_reg;
                    cmd.len       = s_data.frame_len;
                    rx_state_next = RX_DONE;
                end
            end
            default: begin
                cmd.status = dndc_pkg::ST_UNEXP;
            end
        endcase
    end

    assign cmd_push = accept && cmd_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_state_reg <= TX_IDLE;
            rx_state_reg <= RX_INIT;
            tx_base_reg  <= '0;
            rx_base_reg  <= '0;
            rx_desc_reg  <= '0;
            rx_buf_reg   <= '0;
            tx_faddr_reg <= '0;
            tx_flen_reg  <= '0;
        end else if (accept) begin
            tx_state_reg <= tx_state_next;
            rx_state_reg <= rx_state_next;
            tx_base_reg  <= tx_base_next;
            rx_base_reg  <= rx_base_next;
            rx_desc_reg  <= rx_desc_next;
            rx_buf_reg   <= rx_buf_next;
            tx_faddr_reg <= tx_faddr_next;
            tx_flen_reg  <= tx_flen_next;
        end
    end

endmodule

// ===== hdl/dndc_back.sv =====
// ============================================================================
// dndc_back
// Expands each queued command into one to three results, one per cycle
// while the sink accepts them, through a registered output stage.
// ============================================================================
module dndc_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  dndc_pkg::cmd_t      head,
    input  dndc_pkg::q_status_t q_stat,
    output logic                pop,
    input  dndc_pkg::irq_cfg_t  irq_cfg,
    output logic                m_valid,
    input  logic                m_ready,
    output dndc_pkg::out_item_t m_data
);

    logic [1:0]          step_reg, step_next;
    logic                m_valid_reg, m_valid_next;
    dndc_pkg::out_item_t m_data_reg;
    dndc_pkg::out_item_t res;
    logic                load;

    always_comb begin
        res.kind        = dndc_pkg::KIND_STATUS;
        res.target_addr = '0;
        res.payload     = '0;
        res.length      = '0;
        res.status      = head.status;
        res.last        = 1'b1;
        case (head.op)
            dndc_pkg::CMD_STATUS: begin
                res.kind = dndc_pkg::KIND_STATUS;
            end
            dndc_pkg::CMD_READ: begin
                res.kind        = dndc_pkg::KIND_READ;
                res.target_addr = head.addr;
                res.length      = head.len;
            end
            dndc_pkg::CMD_TXIRQ: begin
                res.kind        = dndc_pkg::KIND_IRQ;
                res.target_addr = irq_cfg.tx_irq_addr;
                res.payload     = 64'(irq_cfg.tx_irq_data);
                res.length      = dndc_pkg::IRQ_LEN;
            end
            dndc_pkg::CMD_XMIT: begin
                if (step_reg == 2'd0) begin
                    res.kind        = dndc_pkg::KIND_XMIT;
                    res.target_addr = head.addr;
                    res.length      = head.len;
                    res.last        = 1'b0;
                end else begin
                    res.kind        = dndc_pkg::KIND_IRQ;
                    res.target_addr = irq_cfg.tx_irq_addr;
                    res.payload     = 64'(irq_cfg.tx_irq_data);
                    res.length      = dndc_pkg::IRQ_LEN;
                end
            end
            dndc_pkg::CMD_RXPKT: begin
                if (step_reg == 2'd0) begin
                    res.kind        = dndc_pkg::KIND_PKTWR;
                    res.target_addr = head.addr;
                    res.length      = head.len;
                    res.last        = 1'b0;
                end else if (step_reg == 2'd1) begin
                    res.kind        = dndc_pkg::KIND_DESCWR;
                    res.target_addr = head.aux;
                    res.payload     = head.addr;
                    res.length      = head.len;
                    res.last        = 1'b0;
                end else begin
                    res.kind        = dndc_pkg::KIND_IRQ;
                    res.target_addr = irq_cfg.rx_irq_addr;
                    res.payload     = 64'(irq_cfg.rx_irq_data);
                    res.length      = dndc_pkg::IRQ_LEN;
                end
            end
            default: begin
                res.status = dndc_pkg::ST_UNEXP;
            end
        endcase
    end

    assign load = !q_stat.empty && (!m_valid_reg || m_ready);
    assign pop  = load && res.last;

    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            step_next    = res.last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
